FILE: design/uptwc_pkg.sv
// Shared types and constants for the user page-table walk counter.
package uptwc_pkg;

  localparam int IDX_W   = 9;
  localparam int FRAME_W = 36;
  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 28;
  localparam int WORD_W  = 64;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam int DESC_VALID_BIT = 0;
  localparam int DESC_EL0_BIT   = 6;
  localparam logic [1:0] DESC_TABLE = 2'b11;

  localparam logic [COUNT_W-1:0] PAGES_1G = COUNT_W'(262144);
  localparam logic [COUNT_W-1:0] PAGES_2M = COUNT_W'(512);
  localparam logic [COUNT_W-1:0] L3_PAGE  = COUNT_W'(1);

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LVL_L1 = 2'd0,
    LVL_L2 = 2'd1,
    LVL_L3 = 2'd2,
    LVL_X  = 2'd3
  } level_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DESC  = 1'b1
  } command_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  read_address;
    logic [COUNT_W-1:0] page_count;
  } result_t;

  // Table frame is address bits 47:12.
  function automatic logic [FRAME_W-1:0] frame_of(input logic [WORD_W-1:0] word);
    frame_of = word[12 +: FRAME_W];
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [FRAME_W-1:0] frame,
                                                   input logic [IDX_W-1:0] idx);
    entry_addr = {frame, idx, 3'b000};
  endfunction

endpackage

FILE: design/uptwc_if.sv
// Valid/ready channel interfaces for walk commands and walk results.
interface uptwc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [uptwc_pkg::WORD_W-1:0]  root_value;
  logic [uptwc_pkg::WORD_W-1:0]  descriptor;

  modport source (output valid, command, root_value, descriptor, input ready);
  modport sink   (input valid, command, root_value, descriptor, output ready);
endinterface

interface uptwc_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [uptwc_pkg::ADDR_W-1:0]  read_address;
  logic [uptwc_pkg::COUNT_W-1:0] page_count;

  modport source (output valid, kind, read_address, page_count, input ready);
  modport sink   (input valid, kind, read_address, page_count, output ready);
endinterface

FILE: design/uptwc_walker.sv
// Walk state and combinational descriptor classification.
module uptwc_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          command,
  input  logic [uptwc_pkg::WORD_W-1:0]  root_value,
  input  logic [uptwc_pkg::WORD_W-1:0]  descriptor,
  output uptwc_pkg::result_t            res
);
  import uptwc_pkg::*;

  logic                walk_active, walk_active_next;
  level_t              current_level, current_level_next;
  logic [IDX_W-1:0]    first_index, first_index_next;
  logic [IDX_W-1:0]    second_index, second_index_next;
  logic [IDX_W-1:0]    third_index, third_index_next;
  logic [FRAME_W-1:0]  first_table_frame, first_table_frame_next;
  logic [FRAME_W-1:0]  second_table_frame, second_table_frame_next;
  logic [FRAME_W-1:0]  third_table_frame, third_table_frame_next;
  logic [COUNT_W-1:0]  page_total, page_total_next;

  logic                desc_valid, desc_el0, desc_table, descend, wrap, step_l2, step_l1;
  logic [COUNT_W-1:0]  add_pages;
  logic [ADDR_W-1:0]   next_addr;

  assign desc_valid = descriptor[DESC_VALID_BIT];
  assign desc_el0   = descriptor[DESC_EL0_BIT];
  assign desc_table = (descriptor[1:0] == DESC_TABLE);

  always_comb begin
    case (current_level_next)
      LVL_L1:  next_addr = entry_addr(first_table_frame_next, first_index_next);
      LVL_L2:  next_addr = entry_addr(second_table_frame_next, second_index_next);
      default: next_addr = entry_addr(third_table_frame_next, third_index_next);
    endcase
  end

  always_comb begin
    walk_active_next        = walk_active;
    current_level_next      = current_level;
    first_index_next        = first_index;
    second_index_next       = second_index;
    third_index_next        = third_index;
    first_table_frame_next  = first_table_frame;
    second_table_frame_next = second_table_frame;
    third_table_frame_next  = third_table_frame;
    page_total_next         = page_total;
    descend                 = 1'b0;
    wrap                    = 1'b0;
    step_l2                 = 1'b0;
    step_l1                 = 1'b0;
    add_pages               = '0;
    res.kind                = KIND_REJECT;
    res.read_address        = '0;
    res.page_count          = '0;

    if (command == CMD_START) begin
      if (!walk_active) begin
        if (root_value == '0) begin
          res.kind = KIND_DONE;
        end else begin
          walk_active_next       = 1'b1;
          current_level_next     = LVL_L1;
          first_index_next       = '0;
          second_index_next      = '0;
          third_index_next       = '0;
          first_table_frame_next = frame_of(root_value);
          page_total_next        = '0;
          res.kind               = KIND_READ;
          res.read_address       = next_addr;
        end
      end
    end else if (walk_active) begin
      if (desc_valid) begin
        case (current_level)
          LVL_L1: begin
            if (desc_table) begin
              descend                 = 1'b1;
              second_table_frame_next = frame_of(descriptor);
              second_index_next       = '0;
              current_level_next      = LVL_L2;
            end else if (desc_el0) begin
              add_pages = PAGES_1G;
            end
          end
          LVL_L2: begin
            if (desc_table) begin
              descend                = 1'b1;
              third_table_frame_next = frame_of(descriptor);
              third_index_next       = '0;
              current_level_next     = LVL_L3;
            end else if (desc_el0) begin
              add_pages = PAGES_2M;
            end
          end
          default: begin
            if (desc_el0) add_pages = L3_PAGE;
          end
        endcase
      end

      if (descend) begin
        res.kind         = KIND_READ;
        res.read_address = next_addr;
      end else begin
        page_total_next = page_total + add_pages;
        // index advance: an index that wraps pops one level up
        step_l2 = (current_level == LVL_L2);
        step_l1 = (current_level == LVL_L1);
        if (current_level[1]) begin
          if (third_index != IDX_MAX) begin
            third_index_next = third_index + IDX_W'(1);
          end else begin
            third_index_next   = '0;
            current_level_next = LVL_L2;
            step_l2            = 1'b1;
          end
        end
        if (step_l2) begin
          if (second_index != IDX_MAX) begin
            second_index_next = second_index + IDX_W'(1);
          end else begin
            second_index_next  = '0;
            current_level_next = LVL_L1;
            step_l1            = 1'b1;
          end
        end
        if (step_l1) begin
          if (first_index != IDX_MAX) begin
            first_index_next = first_index + IDX_W'(1);
          end else begin
            first_index_next = '0;
            wrap             = 1'b1;
          end
        end
        if (wrap) begin
          walk_active_next   = 1'b0;
          current_level_next = LVL_L1;
          res.kind           = KIND_DONE;
          res.page_count     = page_total_next;
        end else begin
          res.kind         = KIND_READ;
          res.read_address = next_addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active        <= 1'b0;
      current_level      <= LVL_L1;
      first_index        <= '0;
      second_index       <= '0;
      third_index        <= '0;
      first_table_frame  <= '0;
      second_table_frame <= '0;
      third_table_frame  <= '0;
      page_total         <= '0;
    end else if (take) begin
      walk_active        <= walk_active_next;
      current_level      <= current_level_next;
      first_index        <= first_index_next;
      second_index       <= second_index_next;
      third_index        <= third_index_next;
      first_table_frame  <= first_table_frame_next;
      second_table_frame <= second_table_frame_next;
      third_table_frame  <= third_table_frame_next;
      page_total         <= page_total_next;
    end
  end

endmodule

FILE: design/uptwc_result_reg.sv
// Result register that decouples the output handshake from the walker.
module uptwc_result_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  uptwc_pkg::result_t res,
  output logic               can_load,
  uptwc_out_if.source        results
);
  import uptwc_pkg::*;

  logic    valid;
  result_t data;

  // free when empty or when the held result transfers this cycle
  assign can_load = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign results.valid        = valid;
  assign results.kind         = data.kind;
  assign results.read_address = data.read_address;
  assign results.page_count   = data.page_count;

endmodule

FILE: design/user_page_table_walk_counter_top.sv
// Top level: walk command channel in, one result per accepted item out.
// A result is registered and is visible in the cycle after its item transfers.
// Throughput: one item per cycle unless a held result stalls; the walk state
// and the result register update together at each transfer.
// Reset (rst, synchronous): walker idle, all indices, frames and total zero,
// result register empty.
module user_page_table_walk_counter_top (
  input  logic        clk,
  input  logic        rst,
  uptwc_in_if.sink    items,
  uptwc_out_if.source results
);
  import uptwc_pkg::*;

  logic    can_load;
  logic    take;
  result_t res;

  assign items.ready = can_load;
  assign take        = items.valid && can_load;

  uptwc_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .command    (items.command),
    .root_value (items.root_value),
    .descriptor (items.descriptor),
    .res        (res)
  );

  uptwc_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .can_load (can_load),
    .results  (results)
  );

endmodule

FILE: verif/user_page_table_walk_counter_top_test.sv
`timescale 1ns / 100ps
// Testbench for the page-table walk counter: random walks checked against a predicted result stream.
module user_page_table_walk_counter_top_test;
  import uptwc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TOTAL_ITEMS = 600;
  localparam int DEEP_CUTOFF = 3000;

  typedef enum {WALK_FLAT, WALK_DEEP, WALK_FULL} walk_mode_t;

  // Tracks the walker state and the results that accepted items must produce.
  class walk_scoreboard;
    bit active;
    level_t lvl = LVL_L1;
    logic [IDX_W-1:0] idx1 = '0;
    logic [IDX_W-1:0] idx2 = '0;
    logic [IDX_W-1:0] idx3 = '0;
    logic [FRAME_W-1:0] frame1 = '0;
    logic [FRAME_W-1:0] frame2 = '0;
    logic [FRAME_W-1:0] frame3 = '0;
    logic [COUNT_W-1:0] total = '0;
    logic [COUNT_W-1:0] top_total = '0;
    result_t pending[$];
    int errors;
    int checked;
    int walks_done;
    int rejects;

    function logic [ADDR_W-1:0] next_read();
      case (lvl)
        LVL_L1: return {frame1, idx1, 3'b000};
        LVL_L2: return {frame2, idx2, 3'b000};
        default: return {frame3, idx3, 3'b000};
      endcase
    endfunction

    // Step to the next entry; returns 1 when the L1 index wraps.
    function bit bump_index();
      if (lvl == LVL_L3 || lvl == LVL_X) begin
        idx3 = idx3 + 1'b1;
        if (idx3 != '0) return 1'b0;
        lvl = LVL_L2;
      end
      if (lvl == LVL_L2) begin
        idx2 = idx2 + 1'b1;
        if (idx2 != '0) return 1'b0;
        lvl = LVL_L1;
      end
      idx1 = idx1 + 1'b1;
      return idx1 == '0;
    endfunction

    function void push(kind_t k, logic [ADDR_W-1:0] a, logic [COUNT_W-1:0] c);
      result_t r;
      r.kind = k;
      r.read_address = a;
      r.page_count = c;
      pending.push_back(r);
    endfunction

    function void note_item(command_t cmd, logic [WORD_W-1:0] root, logic [WORD_W-1:0] desc);
      bit descended;
      bit el0;
      bit tbl;
      descended = 1'b0;
      el0 = desc[DESC_EL0_BIT];
      tbl = desc[1:0] == DESC_TABLE;
      if (cmd == CMD_START) begin
        if (active) begin
          push(KIND_REJECT, '0, '0);
          rejects++;
        end else if (root == '0) begin
          push(KIND_DONE, '0, '0);
        end else begin
          active = 1'b1;
          lvl = LVL_L1;
          idx1 = '0;
          idx2 = '0;
          idx3 = '0;
          frame1 = root[12 +: FRAME_W];
          total = '0;
          push(KIND_READ, next_read(), '0);
        end
      end else if (!active) begin
        push(KIND_REJECT, '0, '0);
        rejects++;
      end else begin
        if (desc[DESC_VALID_BIT]) begin
          case (lvl)
            LVL_L1: begin
              if (tbl) begin
                frame2 = desc[12 +: FRAME_W];
                idx2 = '0;
                lvl = LVL_L2;
                descended = 1'b1;
              end else if (el0) begin
                total = total + PAGES_1G;
              end
            end
            LVL_L2: begin
              if (tbl) begin
                frame3 = desc[12 +: FRAME_W];
                idx3 = '0;
                lvl = LVL_L3;
                descended = 1'b1;
              end else if (el0) begin
                total = total + PAGES_2M;
              end
            end
            // type bits are ignored at the last level
            default: if (el0) total = total + L3_PAGE;
          endcase
        end
        if (descended) begin
          push(KIND_READ, next_read(), '0);
        end else if (bump_index()) begin
          active = 1'b0;
          lvl = LVL_L1;
          walks_done++;
          if (total > top_total) top_total = total;
          push(KIND_DONE, '0, total);
        end else begin
          push(KIND_READ, next_read(), '0);
        end
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] count);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d addr %h count %0d", kind, addr, count));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (kind != want.kind)
        report($sformatf("result %0d: kind %0d, want %0d", checked, kind, want.kind));
      if (addr != want.read_address)
        report($sformatf("result %0d: read_address %h, want %h", checked, addr,
                         want.read_address));
      if (count != want.page_count)
        report($sformatf("result %0d: page_count %0d, want %0d", checked, count,
                         want.page_count));
    endtask
  endclass

  logic clk;
  logic rst;
  uptwc_in_if item_bus();
  uptwc_out_if result_bus();

  user_page_table_walk_counter_top uut (
    .clk(clk),
    .rst(rst),
    .items(item_bus),
    .results(result_bus)
  );

  walk_scoreboard board = new();
  int sent;
  int cycles;
  int stall_left;
  bit hold;
  bit send_quiet;
  bit recv_quiet;
  walk_mode_t mode;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending.size());
      $display("[user_page_table_walk_counter_top] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches, and the long hold-off.
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.kind, result_bus.read_address, result_bus.page_count);
      if ($urandom_range(0, 499) == 0) recv_quiet = !recv_quiet;
      pick = $urandom_range(0, 99);
      if (hold) begin
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (recv_quiet || pick < 65) begin
        result_bus.ready <= 1'b1;
      end else if (pick < 95) begin
        stall_left = $urandom_range(0, 2);
        result_bus.ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        result_bus.ready <= 1'b0;
      end
    end
  end

  // Back-pressure: block the result side long enough for the input to stall.
  initial begin
    hold = 1'b0;
    wait (sent >= 60);
    @(posedge clk);
    hold <= 1'b1;
    repeat (300) @(posedge clk);
    hold <= 1'b0;
  end

  function int pick_gap();
    int pick;
    if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
    if (send_quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task send_item(command_t cmd, logic [WORD_W-1:0] root, logic [WORD_W-1:0] desc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.command <= cmd;
    item_bus.root_value <= root;
    item_bus.descriptor <= desc;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    board.note_item(cmd, root, desc);
    sent++;
  endtask

  function logic [WORD_W-1:0] make_root();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return WORD_W'($urandom_range(1, 4095));  // nonzero, frame zero
    return {$urandom, $urandom};
  endfunction

  // Descriptor for the current level, shaped by the walk's mode.
  function logic [WORD_W-1:0] make_desc();
    logic [WORD_W-1:0] w;
    int pick;
    w = {$urandom, $urandom};
    if (board.lvl == LVL_L3) return w;
    pick = $urandom_range(0, 511);
    if (mode == WALK_FULL && board.lvl == LVL_L1) begin
      w[1:0] = 2'b01;
      w[DESC_EL0_BIT] = 1'b1;
    end else if (mode == WALK_DEEP && pick == 0 && sent < DEEP_CUTOFF) begin
      w[1:0] = DESC_TABLE;
    end else begin
      case (pick % 4)
        0, 1: w[DESC_VALID_BIT] = 1'b0;
        2: w[1:0] = 2'b01;
        default: begin
          w[1:0] = 2'b01;
          w[DESC_EL0_BIT] = 1'b1;
        end
      endcase
    end
    return w;
  endfunction

  initial begin
    int pick;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.command = CMD_START;
    item_bus.root_value = '0;
    item_bus.descriptor = '0;
    result_bus.ready = 1'b0;
    mode = WALK_DEEP;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: descriptor while idle, zero root
    send_item(CMD_DESC, '0, '1);
    send_item(CMD_START, '0, '1);

    // one complete walk where every L1 entry is a user block: largest total
    mode = WALK_FULL;
    send_item(CMD_START, {$urandom, $urandom} | 64'h1000, {$urandom, $urandom});
    while (board.active) send_item(CMD_DESC, {$urandom, $urandom}, make_desc());

    // directed: start while busy, then descriptors of several classes at each level
    mode = WALK_DEEP;
    send_item(CMD_START, '1, '0);
    send_item(CMD_START, 64'h1234, '0);
    send_item(CMD_DESC, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(CMD_DESC, '0, 64'h41);
    send_item(CMD_DESC, '0, 64'h1);
    send_item(CMD_DESC, '0, '1);
    send_item(CMD_DESC, '0, 64'h41);
    send_item(CMD_DESC, '0, 64'h40);
    send_item(CMD_DESC, '0, 64'h8000_0000_0000_0000);
    send_item(CMD_DESC, '0, 64'hA5A5_0F0F_F0F0_5A5B);
    send_item(CMD_DESC, '0, 64'h41);
    send_item(CMD_DESC, '0, 64'h43);
    send_item(CMD_DESC, '0, 64'h03);
    send_item(CMD_DESC, '0, 64'h42);
    send_item(CMD_DESC, '0, '1);

    // random traffic until the item budget is spent; a walk may be left open
    while (sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 23);
      if (pick == 0) begin
        // wrong command for the current state
        if (board.active) send_item(CMD_START, make_root(), {$urandom, $urandom});
        else send_item(CMD_DESC, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (!board.active) begin
        mode = walk_mode_t'($urandom_range(0, 2));
        send_item(CMD_START, make_root(), {$urandom, $urandom});
      end else begin
        send_item(CMD_DESC, {$urandom, $urandom}, make_desc());
      end
    end
    item_bus.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d walks finished, %0d rejected",
             sent, board.checked, board.walks_done, board.rejects);
    $display("largest walk total %0d pages", board.top_total);
    if (board.errors == 0) begin
      $display("[user_page_table_walk_counter_top] OK");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("[user_page_table_walk_counter_top] ERROR");
    end
    $finish;
  end

endmodule
